FILE: hw/rtl/spq_pkg.sv
package spq_pkg;

    localparam int CAPACITY_DEF  = 16;
    localparam int PRIO_BITS_DEF = 16;

    localparam int VALUE_W = 32;
    localparam int PRIO_W  = 16;
    localparam int COUNT_W = 5;
    localparam int KIND_W  = 2;

    localparam logic [KIND_W-1:0] KIND_ENQ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEQ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK = 2'd2;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } err_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]  prio;
    } entry_t;

    typedef struct packed {
        logic   enq;
        logic   deq;
        entry_t fresh;
    } cell_ctl_t;

endpackage

FILE: hw/rtl/spq_cell.sv
module spq_cell
    import spq_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  logic      occupied,
    input  logic      left_keep,
    input  entry_t    left_entry,
    input  entry_t    right_entry,
    output logic      keep,
    output entry_t    entry,
    output entry_t    entry_next
);

    entry_t entry_reg;

    assign entry = entry_reg;
    assign keep  = occupied && (entry_reg.prio <= ctl.fresh.prio);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.enq)
        begin
            if (keep)
                entry_next = entry_reg;
            else if (left_keep)
                entry_next = ctl.fresh;
            else
                entry_next = left_entry;
        end
        else if (ctl.deq)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

FILE: hw/rtl/stable_priority_queue.sv
// Bounded priority queue, smallest priority first, equal priorities in arrival
// order. Each item is an enqueue, a dequeue of the head or a peek, and yields
// one result: head value and priority after the operation (zero when empty),
// entry count and an error code (1 enqueue refused when full, 2 dequeue or peek
// on empty; kind 3 acts as peek). Entries sit in a row of CAPACITY cells that
// compare against the incoming priority and shift left or right all at once,
// so one item is taken every cycle while in_stall is low, and its result is
// shown the cycle after from output registers fed by the combinational shift.
module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int PRIO_BITS = PRIO_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [KIND_W-1:0]         kind,
    input  logic signed [VALUE_W-1:0] item_value,
    input  logic [PRIO_W-1:0]         item_priority,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [VALUE_W-1:0] head_value,
    output logic [PRIO_W-1:0]         head_priority,
    output logic [COUNT_W-1:0]        entry_count,
    output logic [1:0]                op_error
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [PRIO_W-1:0] PRIO_MASK = (PRIO_BITS >= PRIO_W) ? {PRIO_W{1'b1}}
        : PRIO_W'((64'd1 << PRIO_BITS) - 64'd1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    logic [CW-1:0]      count_reg, count_next;
    logic               out_valid_reg;
    logic [VALUE_W-1:0] head_value_reg;
    logic [PRIO_W-1:0]  head_priority_reg;
    logic [CW-1:0]      count_out_reg;
    err_t               err_reg, err_next;

    logic      accept, full, empty, is_enq, is_deq;
    cell_ctl_t ctl;
    entry_t    cell_q    [CAPACITY];
    entry_t    cell_d    [CAPACITY];
    logic      cell_keep [CAPACITY];

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign full     = (count_reg == FULL_COUNT);
    assign empty    = (count_reg == '0);
    assign is_enq   = (kind == KIND_ENQ);
    assign is_deq   = (kind == KIND_DEQ);

    always_comb
    begin
        ctl.enq         = accept && is_enq && !full;
        ctl.deq         = accept && is_deq && !empty;
        ctl.fresh.value = item_value;
        ctl.fresh.prio  = item_priority & PRIO_MASK;
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            entry_t left_e, right_e;
            logic   left_k;
            if (g == 0)
            begin : g_first
                assign left_e = ctl.fresh;
                assign left_k = 1'b1;
            end
            else
            begin : g_inner
                assign left_e = cell_q[g-1];
                assign left_k = cell_keep[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_last
                assign right_e = cell_q[g];
            end
            else
            begin : g_mid
                assign right_e = cell_q[g+1];
            end
            spq_cell u_cell (
                .clk         (clk),
                .ctl         (ctl),
                .occupied    (CW'(g) < count_reg),
                .left_keep   (left_k),
                .left_entry  (left_e),
                .right_entry (right_e),
                .keep        (cell_keep[g]),
                .entry       (cell_q[g]),
                .entry_next  (cell_d[g])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        err_next   = ERR_NONE;
        if (ctl.enq)
            count_next = count_reg + CW'(1);
        else if (ctl.deq)
            count_next = count_reg - CW'(1);
        if (is_enq && full)
            err_next = ERR_FULL;
        else if (!is_enq && empty)
            err_next = ERR_EMPTY;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            count_out_reg <= count_next;
            err_reg       <= err_next;
            if (count_next == '0)
            begin
                head_value_reg    <= '0;
                head_priority_reg <= '0;
            end
            else
            begin
                head_value_reg    <= cell_d[0].value;
                head_priority_reg <= cell_d[0].prio;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign head_value    = head_value_reg;
    assign head_priority = head_priority_reg;
    assign entry_count   = COUNT_W'(count_out_reg);
    assign op_error      = err_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count beyond capacity");

    a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.enq |=> count_reg == $past(count_reg) + CW'(1))
        else $error("enqueue did not add an entry");

    a_refused_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !ctl.enq && !ctl.deq) |=> $stable(count_reg))
        else $error("count changed on a refused or peek item");

    a_empty_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && err_reg == ERR_EMPTY) |->
        (count_out_reg == '0 && head_value_reg == '0 && head_priority_reg == '0))
        else $error("empty error with non-empty result");

endmodule

FILE: verif/testbench.sv
module testbench;
    import spq_pkg::*;

    localparam logic [KIND_W-1:0] KIND_PEEK_ALT = 2'd3;
    localparam logic [PRIO_W-1:0] PRIO_KEEP = PRIO_W'((64'd1 << PRIO_BITS_DEF) - 64'd1);
    localparam int RANDOM_ITEMS = 1030;
    localparam int HOLD_POINT = 500;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic [KIND_W-1:0]         op;
        logic signed [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]         prio;
        bit                        hold;
    } pending_op_t;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]         prio;
        logic [COUNT_W-1:0]        count;
        err_t                      err;
    } head_report_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [KIND_W-1:0]         kind = KIND_PEEK;
    logic signed [VALUE_W-1:0] item_value = '0;
    logic [PRIO_W-1:0]         item_priority = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [VALUE_W-1:0] head_value;
    logic [PRIO_W-1:0]         head_priority;
    logic [COUNT_W-1:0]        entry_count;
    logic [1:0]                op_error;

    pending_op_t  op_backlog[$];
    head_report_t heads_due[$];
    head_report_t want;

    logic signed [VALUE_W-1:0] held_value[CAPACITY_DEF];
    logic [PRIO_W-1:0]         held_prio[CAPACITY_DEF];
    int                        held = 0;

    int backlog_left;
    int open_results = 0;
    int mismatches = 0;
    int idle_cycles = 0;
    int burst_left = 1;
    int gap_left = 0;
    int stall_mode = 0;
    int mode_left = 0;
    int stall_phase = 0;

    stable_priority_queue DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .item_value    (item_value),
        .item_priority (item_priority),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .head_value    (head_value),
        .head_priority (head_priority),
        .entry_count   (entry_count),
        .op_error      (op_error)
    );

    always #5 clk = ~clk;

    function automatic head_report_t apply_queue_op(input logic [KIND_W-1:0] op,
                                                    input logic signed [VALUE_W-1:0] value,
                                                    input logic [PRIO_W-1:0] prio);
        head_report_t res;
        logic [PRIO_W-1:0] kept;
        int pos;
        kept = prio & PRIO_KEEP;
        res.err = ERR_NONE;
        if (op == KIND_ENQ)
        begin
            if (held >= CAPACITY_DEF)
                res.err = ERR_FULL;
            else
            begin
                pos = 0;
                while (pos < held && held_prio[pos] <= kept)
                    pos++;
                for (int i = held; i > pos; i--)
                begin
                    held_value[i] = held_value[i-1];
                    held_prio[i] = held_prio[i-1];
                end
                held_value[pos] = value;
                held_prio[pos] = kept;
                held++;
            end
        end
        else if (op == KIND_DEQ)
        begin
            if (held == 0)
                res.err = ERR_EMPTY;
            else
            begin
                for (int i = 1; i < held; i++)
                begin
                    held_value[i-1] = held_value[i];
                    held_prio[i-1] = held_prio[i];
                end
                held--;
            end
        end
        else if (held == 0)
        begin
            res.err = ERR_EMPTY;
        end
        res.value = (held > 0) ? held_value[0] : '0;
        res.prio = (held > 0) ? held_prio[0] : '0;
        res.count = COUNT_W'(held);
        return res;
    endfunction

    task automatic add_op(input logic [KIND_W-1:0] op, input logic signed [VALUE_W-1:0] value,
                          input logic [PRIO_W-1:0] prio, input bit hold);
        pending_op_t p;
        p.op = op;
        p.value = value;
        p.prio = prio;
        p.hold = hold;
        op_backlog.push_back(p);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
                void'(op_backlog.pop_front());
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (op_backlog.size() != 0
                     && (!op_backlog[0].hold || (!in_valid && open_results == 0)))
            begin
                in_valid <= 1'b1;
                kind <= op_backlog[0].op;
                item_value <= op_backlog[0].value;
                item_priority <= op_backlog[0].prio;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
            backlog_left <= op_backlog.size();
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            stall_phase++;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 1) == 0);
                2: out_stall <= ($urandom_range(0, 7) != 0);
                default: out_stall <= ((stall_phase % 5) < 2);
            endcase
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_results <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                heads_due.push_back(apply_queue_op(kind, item_value, item_priority));
            if (out_valid && !out_stall)
            begin
                if (heads_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: value %0d prio %0d count %0d err %0d",
                                 head_value, head_priority, entry_count, op_error);
                end
                else
                begin
                    want = heads_due.pop_front();
                    if (head_value !== want.value || head_priority !== want.prio
                        || entry_count !== want.count || op_error !== want.err)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                                     want.value, want.prio, want.count, want.err,
                                     head_value, head_priority, entry_count, op_error);
                    end
                end
            end
            open_results <= heads_due.size();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int run;
        int fill_pct;
        int r;
        int random_done;
        logic [KIND_W-1:0] op;
        logic [PRIO_W-1:0] prio;

        add_op(KIND_PEEK, $urandom, PRIO_W'($urandom), 1'b0);
        add_op(KIND_DEQ, $urandom, PRIO_W'($urandom), 1'b0);
        add_op(KIND_PEEK_ALT, $urandom, PRIO_W'($urandom), 1'b0);
        add_op(KIND_ENQ, 32'sd5, 16'd7, 1'b0);
        add_op(KIND_DEQ, $urandom, PRIO_W'($urandom), 1'b0);
        add_op(KIND_ENQ, 32'sh7fff_ffff, 16'hffff, 1'b0);
        add_op(KIND_ENQ, 32'sh8000_0000, 16'h0000, 1'b0);
        add_op(KIND_ENQ, 32'sd0, 16'h0000, 1'b0);
        add_op(KIND_ENQ, -32'sd1, 16'hffff, 1'b0);
        add_op(KIND_PEEK, $urandom, PRIO_W'($urandom), 1'b0);
        add_op(KIND_PEEK_ALT, $urandom, PRIO_W'($urandom), 1'b0);
        add_op(KIND_DEQ, $urandom, PRIO_W'($urandom), 1'b0);
        repeat (13)
            add_op(KIND_ENQ, $urandom, PRIO_W'($urandom_range(0, 3)), 1'b0);
        add_op(KIND_ENQ, $urandom, 16'd1, 1'b0);

        random_done = 0;
        while (random_done < RANDOM_ITEMS)
        begin
            fill_pct = 25 * $urandom_range(1, 3);
            run = $urandom_range(20, 80);
            if (run > RANDOM_ITEMS - random_done)
                run = RANDOM_ITEMS - random_done;
            repeat (run)
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    op = KIND_PEEK;
                else if (r < 11)
                    op = KIND_PEEK_ALT;
                else if ($urandom_range(0, 99) < fill_pct)
                    op = KIND_ENQ;
                else
                    op = KIND_DEQ;
                case ($urandom_range(0, 3))
                    0: prio = PRIO_W'($urandom_range(0, 3));
                    1: prio = PRIO_W'($urandom_range(0, 15));
                    2: prio = PRIO_W'($urandom);
                    default: prio = ($urandom_range(0, 1) == 0) ? '0 : '1;
                endcase
                add_op(op, $urandom, prio, random_done == 0 || random_done == HOLD_POINT);
                random_done++;
            end
        end
        backlog_left = op_backlog.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (backlog_left != 0 || in_valid || open_results != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);

        if (mismatches == 0 && heads_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
